/* src/mavt_pkg.sv */
// Package for the multi-turn angle and velocity tracker.
// Holds field widths, constants, command/status structs and the controller state type.
// No dependencies.
package mavt_pkg;

  // Field widths
  localparam int RAW_BITS   = 15;
  localparam int STAMP_BITS = 24;
  localparam int ANGLE_BITS = 39;
  localparam int VEL_BITS   = 48;
  localparam int TPU_BITS   = 8;
  localparam int THR_BITS   = 15;
  localparam int KIND_BITS  = 2;
  localparam int CFG_BITS   = 15;
  localparam int MAG_BITS   = ANGLE_BITS + 1;
  localparam int HALF_BITS  = MAG_BITS / 2;
  localparam int K_BITS     = 28;
  localparam int PP_BITS    = HALF_BITS + K_BITS;
  localparam int PROD_BITS  = MAG_BITS + K_BITS;
  localparam int QUOT_BITS  = VEL_BITS - 1;
  localparam int DIV_STEPS  = QUOT_BITS;
  localparam int CNT_BITS   = $clog2(DIV_STEPS);

  // Request kinds
  localparam logic [KIND_BITS-1:0] KIND_START = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_ANGLE = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_VEL   = 2'd2;

  // Register indexes
  localparam logic CFG_TPU = 1'b0;
  localparam logic CFG_THR = 1'b1;

  // Register reset values
  localparam logic [TPU_BITS-1:0] TPU_RESET = 8'd9;
  localparam logic [THR_BITS-1:0] THR_RESET = 15'd26214;

  // Timing constants
  localparam logic [STAMP_BITS-1:0] STAMP_MOD = 24'hFFFFFF;
  localparam int US_PER_S  = 1000000;
  localparam int US_HALF_S = 500000;
  localparam int US_PER_MS = 1000;

  // Velocity saturation limits
  localparam logic [VEL_BITS-1:0] VEL_POS_MAX = {1'b0, {(VEL_BITS-1){1'b1}}};
  localparam logic [VEL_BITS-1:0] VEL_NEG_MAX = {1'b1, {(VEL_BITS-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRACK,
    ST_ANGLE,
    ST_DELTA,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV_INIT,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic track;
    logic angle;
    logic delta;
    logic mul_lo;
    logic mul_hi;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic vel_item;
    logic out_free;
  } sts_t;

endpackage

/* src/multiturn_angle_velocity_tracker_top.sv */
// A start or angle request passes the track, angle and output states; a velocity request also
// passes the delta, low and high multiply and divide-init states and the one-bit-per-cycle restoring divider.
// One request at a time; the next is taken once the result is in the output register,
// which is loaded only when that register is free.
// Reset (rst, synchronous): tracking state cleared, ticks_per_us 9, wrap_threshold 26214.
// Top level of the multi-turn angle and velocity tracker; uses mavt_pkg, mavt_ctrl, mavt_dp.
module multiturn_angle_velocity_tracker_top #(
  parameter int COUNTS_PER_TURN = 32768,
  parameter int TURN_BITS       = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [mavt_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [39:0]                   s_tdata,  // raw_angle[14:0], timer_now[38:15]
  input  logic [1:0]                    s_tuser,  // kind[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [87:0]                   m_tdata,  // angle_counts[38:0], velocity_cps[86:39]
  output logic [1:0]                    m_tuser   // velocity_valid[0], interval_fallback[1]
);

  mavt_pkg::cmd_t cmd;
  mavt_pkg::sts_t sts;

  // Sequencer
  mavt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and state
  mavt_dp #(
    .COUNTS_PER_TURN (COUNTS_PER_TURN),
    .TURN_BITS       (TURN_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* src/mavt_ctrl.sv */
// Controller of the multi-turn angle and velocity tracker.
// Sequences tracking, multiply and serial divide steps; depends on mavt_pkg.
module mavt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  mavt_pkg::sts_t  sts,
  output mavt_pkg::cmd_t  cmd
);

  mavt_pkg::state_t state, state_next;
  logic [mavt_pkg::CNT_BITS-1:0] div_cnt, div_cnt_next;
  logic div_last;

  assign div_last = (div_cnt == mavt_pkg::CNT_BITS'(mavt_pkg::DIV_STEPS - 1));

  // State and divide step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mavt_pkg::ST_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  always_comb begin
    div_cnt_next = '0;
    if (state == mavt_pkg::ST_DIV && !div_last) begin
      div_cnt_next = div_cnt + 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mavt_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = mavt_pkg::ST_TRACK;
      end
      mavt_pkg::ST_TRACK:    state_next = mavt_pkg::ST_ANGLE;
      mavt_pkg::ST_ANGLE: begin
        state_next = sts.vel_item ? mavt_pkg::ST_DELTA : mavt_pkg::ST_OUT;
      end
      mavt_pkg::ST_DELTA:    state_next = mavt_pkg::ST_MUL_LO;
      mavt_pkg::ST_MUL_LO:   state_next = mavt_pkg::ST_MUL_HI;
      mavt_pkg::ST_MUL_HI:   state_next = mavt_pkg::ST_DIV_INIT;
      mavt_pkg::ST_DIV_INIT: state_next = mavt_pkg::ST_DIV;
      mavt_pkg::ST_DIV: begin
        if (div_last) state_next = mavt_pkg::ST_OUT;
      end
      mavt_pkg::ST_OUT: begin
        if (sts.out_free) state_next = mavt_pkg::ST_IDLE;
      end
      default: state_next = mavt_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      mavt_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      mavt_pkg::ST_TRACK:    cmd.track    = 1'b1;
      mavt_pkg::ST_ANGLE:    cmd.angle    = 1'b1;
      mavt_pkg::ST_DELTA:    cmd.delta    = 1'b1;
      mavt_pkg::ST_MUL_LO:   cmd.mul_lo   = 1'b1;
      mavt_pkg::ST_MUL_HI:   cmd.mul_hi   = 1'b1;
      mavt_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
      mavt_pkg::ST_DIV:      cmd.div_step = 1'b1;
      mavt_pkg::ST_OUT:      cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

  // Checks
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command at once");
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == mavt_pkg::ST_DIV && div_last) |=> state == mavt_pkg::ST_OUT)
    else $error("divider did not finish after its last step");
  a_short_path: assert property (@(posedge clk) disable iff (rst)
    (state == mavt_pkg::ST_ANGLE && !sts.vel_item) |=> state == mavt_pkg::ST_OUT)
    else $error("angle-only request entered the velocity path");
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    state != mavt_pkg::ST_DIV |-> div_cnt == '0)
    else $error("divide counter not cleared outside the divide loop");

endmodule

/* src/mavt_dp.sv */
// Datapath of the multi-turn angle and velocity tracker.
// Holds tracking state, registers, multiply and restoring divider; depends on mavt_pkg.
module mavt_dp #(
  parameter int COUNTS_PER_TURN = 32768,
  parameter int TURN_BITS       = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [mavt_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic [39:0]                    s_tdata,
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [87:0]                    m_tdata,
  output logic [1:0]                     m_tuser,
  input  mavt_pkg::cmd_t                 cmd,
  output mavt_pkg::sts_t                 sts
);

  localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

  // Configuration
  logic [mavt_pkg::TPU_BITS-1:0] tpu;
  logic [mavt_pkg::THR_BITS-1:0] thr;

  // Request
  logic [mavt_pkg::KIND_BITS-1:0]  kind_r;
  logic [mavt_pkg::RAW_BITS-1:0]   raw_r;
  logic [mavt_pkg::STAMP_BITS-1:0] now_r;

  // Tracking state
  logic [mavt_pkg::RAW_BITS-1:0]   prev_sample;
  logic signed [TURN_BITS-1:0]     turn;
  logic [mavt_pkg::ANGLE_BITS-1:0] prev_angle;
  logic [mavt_pkg::STAMP_BITS-1:0] prev_stamp;

  // Working registers
  logic [mavt_pkg::STAMP_BITS-1:0] ticks;
  logic                            fallback;
  logic [mavt_pkg::ANGLE_BITS-1:0] angle_r;
  logic                            neg;
  logic [mavt_pkg::MAG_BITS-1:0]   a_mag;
  logic [mavt_pkg::K_BITS-1:0]     k_r;
  logic [mavt_pkg::PROD_BITS-1:0]  prod;
  logic [mavt_pkg::STAMP_BITS-1:0] rem;
  logic [mavt_pkg::QUOT_BITS-1:0]  quot;
  logic                            ovf;

  // Combinational terms
  logic                            is_start;
  logic                            is_vel;
  logic [mavt_pkg::TPU_BITS-1:0]   tpu_eff;
  logic [mavt_pkg::STAMP_BITS-1:0] elapsed;
  logic [26:0]                     ticks_max;
  logic [mavt_pkg::STAMP_BITS-1:0] ticks_dflt;
  logic                            bad_interval;
  logic signed [mavt_pkg::RAW_BITS:0] d;
  logic [mavt_pkg::RAW_BITS:0]     dmag;
  logic                            jump;
  logic signed [63:0]              ang_full;
  logic signed [mavt_pkg::MAG_BITS-1:0] delta;
  logic [mavt_pkg::PP_BITS-1:0]    p_lo;
  logic [mavt_pkg::PP_BITS-1:0]    p_hi;
  logic [20:0]                     top_bits;
  logic [mavt_pkg::STAMP_BITS:0]   rem_sh;
  logic                            q_bit;
  logic [mavt_pkg::VEL_BITS-1:0]   vel_mag;
  logic [mavt_pkg::VEL_BITS-1:0]   vel;

  assign is_start = (kind_r == mavt_pkg::KIND_START);
  assign is_vel   = (kind_r == mavt_pkg::KIND_VEL);
  assign tpu_eff  = (tpu == '0) ? mavt_pkg::TPU_BITS'(1) : tpu;

  // Elapsed ticks of the down-counting stamp, with the 1 ms fallback
  always_comb begin
    if (now_r < prev_stamp) begin
      elapsed = prev_stamp - now_r;
    end else begin
      elapsed = mavt_pkg::STAMP_MOD - now_r + prev_stamp;
    end
    ticks_max    = 27'(tpu_eff) * 27'(mavt_pkg::US_HALF_S);
    ticks_dflt   = 24'(tpu_eff) * 24'(mavt_pkg::US_PER_MS);
    bad_interval = (elapsed == '0) || (27'(elapsed) > ticks_max);
  end

  // Wrap detection
  always_comb begin
    d    = signed'({1'b0, raw_r}) - signed'({1'b0, prev_sample});
    dmag = d[mavt_pkg::RAW_BITS] ? 16'(-d) : 16'(d);
    jump = dmag > {1'b0, thr};
  end

  // Multi-turn angle, kept to 39 bits
  assign ang_full = 64'(turn) * 64'(COUNTS_PER_TURN) + signed'(64'(raw_r));
  assign delta    = signed'({angle_r[mavt_pkg::ANGLE_BITS-1], angle_r})
                  - signed'({prev_angle[mavt_pkg::ANGLE_BITS-1], prev_angle});

  // Partial products of |delta| * k
  assign p_lo = mavt_pkg::PP_BITS'(a_mag[mavt_pkg::HALF_BITS-1:0])
              * mavt_pkg::PP_BITS'(k_r);
  assign p_hi = mavt_pkg::PP_BITS'(a_mag[mavt_pkg::MAG_BITS-1:mavt_pkg::HALF_BITS])
              * mavt_pkg::PP_BITS'(k_r);

  // Restoring divide step
  assign top_bits = prod[mavt_pkg::PROD_BITS-1:mavt_pkg::QUOT_BITS];
  assign rem_sh   = {rem, prod[mavt_pkg::QUOT_BITS-1]};
  assign q_bit    = rem_sh >= {1'b0, ticks};

  // Saturated, signed velocity
  always_comb begin
    if (ovf) begin
      vel_mag = neg ? mavt_pkg::VEL_NEG_MAX : mavt_pkg::VEL_POS_MAX;
    end else begin
      vel_mag = {1'b0, quot};
    end
    vel = neg ? (~vel_mag + 1'b1) : vel_mag;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tpu <= mavt_pkg::TPU_RESET;
      thr <= mavt_pkg::THR_RESET;
    end else if (cfg_we) begin
      if (cfg_index == mavt_pkg::CFG_TPU) tpu <= cfg_data[mavt_pkg::TPU_BITS-1:0];
      else                                thr <= cfg_data[mavt_pkg::THR_BITS-1:0];
    end
  end

  // Tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= '0;
      turn        <= '0;
      prev_angle  <= '0;
      prev_stamp  <= '0;
    end else if (cmd.track) begin
      prev_sample <= raw_r;
      if (is_start) begin
        turn       <= '0;
        prev_angle <= mavt_pkg::ANGLE_BITS'(raw_r);
        prev_stamp <= '0;
      end else if (jump) begin
        if (!d[mavt_pkg::RAW_BITS]) begin
          if (turn != TURN_MIN) turn <= turn - 1'b1;
        end else begin
          if (turn != TURN_MAX) turn <= turn + 1'b1;
        end
      end
    end else if (cmd.out_load && is_vel) begin
      prev_angle <= angle_r;
      prev_stamp <= now_r;
    end
  end

  // Request capture and arithmetic steps
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= s_tuser;
      raw_r  <= s_tdata[14:0];
      now_r  <= s_tdata[38:15];
    end
    if (cmd.track) begin
      ticks    <= bad_interval ? ticks_dflt : elapsed;
      fallback <= bad_interval;
    end
    if (cmd.angle) begin
      angle_r <= ang_full[mavt_pkg::ANGLE_BITS-1:0];
    end
    if (cmd.delta) begin
      neg   <= delta[mavt_pkg::MAG_BITS-1];
      a_mag <= delta[mavt_pkg::MAG_BITS-1] ? mavt_pkg::MAG_BITS'(-delta)
                                           : mavt_pkg::MAG_BITS'(delta);
      k_r   <= mavt_pkg::K_BITS'(tpu_eff) * mavt_pkg::K_BITS'(mavt_pkg::US_PER_S);
    end
    if (cmd.mul_lo) begin
      prod <= mavt_pkg::PROD_BITS'(p_lo);
    end
    if (cmd.mul_hi) begin
      prod <= prod + {p_hi, {mavt_pkg::HALF_BITS{1'b0}}};
    end
    if (cmd.div_init) begin
      ovf  <= 24'(top_bits) >= ticks;
      rem  <= 24'(top_bits);
      quot <= '0;
    end
    if (cmd.div_step) begin
      rem  <= q_bit ? 24'(rem_sh - {1'b0, ticks}) : rem_sh[mavt_pkg::STAMP_BITS-1:0];
      quot <= {quot[mavt_pkg::QUOT_BITS-2:0], q_bit};
      prod <= prod << 1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {1'b0, (is_vel ? vel : '0), angle_r};
      m_tuser <= {fallback & is_vel, is_vel};
    end
  end

  assign sts.vel_item = is_vel;
  assign sts.out_free = !m_tvalid || m_tready;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the multi-turn angle and velocity tracker.
// Drives sample requests from a queue, predicts each result and checks it field by field.
// Depends on mavt_pkg and multiturn_angle_velocity_tracker_top.
`timescale 1ns / 1ps

module tb_top;
  import mavt_pkg::*;

  localparam int COUNTS_PER_REV = 32768;
  localparam int TURN_WIDTH     = 24;
  localparam longint TURN_MAX   = (longint'(1) << (TURN_WIDTH - 1)) - 1;
  localparam longint TURN_MIN   = -(longint'(1) << (TURN_WIDTH - 1));
  // kind 3 has no name in the package; the block treats it as a plain angle sample
  localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int SETTLE_CYCLES   = 60;
  localparam int HOLDOFF_CYCLES  = 300;
  localparam int CYCLE_LIMIT     = 1000000;

  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [RAW_BITS-1:0]   raw;
    logic [STAMP_BITS-1:0] stamp;
  } tracker_req_t;

  typedef struct {
    logic signed [ANGLE_BITS-1:0] angle;
    logic signed [VEL_BITS-1:0]   vel;
    logic                         vel_ok;
    logic                         fallback;
  } tracker_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [39:0] s_tdata = '0;  // raw_angle[14:0], timer_now[38:15]
  logic [1:0] s_tuser = '0;   // kind[1:0]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [87:0] m_tdata;       // angle_counts[38:0], velocity_cps[86:39]
  logic [1:0] m_tuser;        // velocity_valid[0], interval_fallback[1]

  // Tracker state and register copies, as the block should hold them
  logic [RAW_BITS-1:0]   last_sample = '0;
  longint                turns = 0;
  longint                last_angle = 0;
  logic [STAMP_BITS-1:0] last_stamp = '0;
  logic [TPU_BITS-1:0]   tpu_cfg = TPU_RESET;
  logic [THR_BITS-1:0]   thr_cfg = THR_RESET;

  tracker_req_t    pending_reqs[$];
  tracker_result_t expected_results[$];
  tracker_req_t    tx_req;

  // Sample generator state: where the encoder is heading
  logic [RAW_BITS-1:0] gen_raw = '0;
  int unsigned         gen_stamp = 0;

  bit  idling_on = 1'b1;
  bit  holdoff_req = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  sent_reqs = 0;
  int  checked_results = 0;
  int  vel_results = 0;
  int  fallback_results = 0;
  int  settings_run = 0;
  int  fail_count = 0;
  int  cycle_count = 0;

  multiturn_angle_velocity_tracker_top #(
    .COUNTS_PER_TURN(COUNTS_PER_REV),
    .TURN_BITS(TURN_WIDTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #4 clk = ~clk;

  // Advance the tracker by one request and work out the result it must give
  function automatic tracker_result_t predict_tracker(input tracker_req_t req);
    tracker_result_t res;
    bit [63:0] tpu, scale, ticks, span, quot, rem, cap, mag;
    longint jump, jump_abs, angle_cur, delta;
    logic signed [ANGLE_BITS-1:0] angle_wrapped;
    logic neg;
    res = '{default: '0};
    if (req.kind == KIND_START) begin
      last_sample = req.raw;
      turns = 0;
      last_angle = longint'(req.raw);
      last_stamp = '0;
      res.angle = ANGLE_BITS'(req.raw);
      return res;
    end

    // unwrap: a big jump means the sample crossed zero
    jump = longint'(req.raw) - longint'(last_sample);
    jump_abs = (jump < 0) ? -jump : jump;
    if (jump_abs > longint'(thr_cfg)) begin
      if (jump > 0) begin
        if (turns > TURN_MIN) turns--;
      end else begin
        if (turns < TURN_MAX) turns++;
      end
    end
    last_sample = req.raw;
    angle_wrapped = ANGLE_BITS'(turns * COUNTS_PER_REV + longint'(req.raw));
    angle_cur = longint'(angle_wrapped);
    res.angle = angle_wrapped;

    if (req.kind == KIND_VEL) begin
      tpu = (tpu_cfg == 0) ? 64'd1 : 64'(tpu_cfg);
      scale = tpu * US_PER_S;
      // the timer counts down and wraps at its modulus
      if (req.stamp < last_stamp) ticks = 64'(last_stamp - req.stamp);
      else ticks = 64'(STAMP_MOD) - 64'(req.stamp) + 64'(last_stamp);
      if (ticks == 0 || ticks > tpu * US_HALF_S) begin
        ticks = tpu * US_PER_MS;
        res.fallback = 1'b1;
      end
      delta = angle_cur - last_angle;
      neg = delta < 0;
      span = neg ? 64'(-delta) : 64'(delta);
      cap = neg ? 64'(VEL_NEG_MAX) : 64'(VEL_POS_MAX);
      quot = span / ticks;
      rem = span % ticks;
      if (quot > cap / scale) begin
        mag = cap;
      end else begin
        mag = quot * scale + (rem * scale) / ticks;
        if (mag > cap) mag = cap;
      end
      res.vel = VEL_BITS'(neg ? (64'd0 - mag) : mag);
      res.vel_ok = 1'b1;
      last_angle = angle_cur;
      last_stamp = req.stamp;
    end
    return res;
  endfunction

  function automatic void push_req(input logic [KIND_BITS-1:0] kind,
                                   input logic [RAW_BITS-1:0] raw,
                                   input logic [STAMP_BITS-1:0] stamp);
    tracker_req_t req;
    req.kind = kind;
    req.raw = raw;
    req.stamp = stamp;
    pending_reqs.push_back(req);
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int roll;
    if (!idling_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(12, 48);
  endfunction

  function automatic logic [RAW_BITS-1:0] next_raw(input int stride_max, input bit fwd);
    int stride;
    stride = $urandom_range(0, stride_max);
    gen_raw = fwd ? gen_raw + RAW_BITS'(stride) : gen_raw - RAW_BITS'(stride);
    return gen_raw;
  endfunction

  // Pick an elapsed interval, aiming at the 1 ms and half-second edges now and then
  function automatic logic [STAMP_BITS-1:0] next_stamp(input bit tiny);
    int unsigned tpu_eff, gap, roll;
    tpu_eff = (tpu_cfg == 0) ? 1 : 32'(tpu_cfg);
    roll = $urandom_range(0, 99);
    if (tiny) gap = $urandom_range(1, 3);
    else if (roll < 50) gap = $urandom_range(1, 20000);
    else if (roll < 60) gap = tpu_eff * US_PER_MS + $urandom_range(0, 2) - 1;
    else if (roll < 75) gap = tpu_eff * US_HALF_S + $urandom_range(0, 2) - 1;
    else if (roll < 83) gap = 0;
    else if (roll < 92) gap = $urandom_range(0, STAMP_MOD);
    else begin
      gen_stamp = $urandom_range(0, STAMP_MOD);
      return STAMP_BITS'(gen_stamp);
    end
    if (gap > STAMP_MOD) gap = $urandom_range(1, STAMP_MOD);
    if (gap <= gen_stamp) gen_stamp = gen_stamp - gap;
    else gen_stamp = gen_stamp + STAMP_MOD - gap;
    return STAMP_BITS'(gen_stamp);
  endfunction

  // Edge cases under the reset settings (9 ticks/us, threshold 26214).
  // Turn counter saturation needs 2^23 crossings and is out of reach in a run this long.
  function automatic void queue_directed();
    push_req(KIND_ANGLE, 15'd0, 24'd0);
    push_req(KIND_VEL, 15'd0, 24'd0);              // equal stamps: over half a second
    push_req(KIND_START, 15'd32767, 24'hABCDEF);
    push_req(KIND_ANGLE, 15'd0, 24'd0);            // crossing upwards
    push_req(KIND_VEL, 15'd32767, 24'hFFFFFF);     // zero elapsed ticks, crossing down
    push_req(KIND_VEL, 15'd16384, 24'd16768215);   // exactly 1 ms
    push_req(KIND_VEL, 15'd16385, 24'd12268215);   // exactly half a second
    push_req(KIND_VEL, 15'd16386, 24'd7768214);    // one tick over half a second
    push_req(KIND_SPARE, 15'd0, 24'h123456);
    push_req(KIND_VEL, 15'd32767, 24'd7768213);    // single tick
    push_req(KIND_ANGLE, 15'd0, 24'hFFFFFF);
    push_req(KIND_VEL, 15'd32767, 24'd0);
    push_req(KIND_START, 15'd0, 24'd0);
    push_req(KIND_VEL, 15'd0, 24'hFFFFFF);
    push_req(KIND_VEL, 15'h5555, 24'hAAAAAA);
    push_req(KIND_VEL, 15'h2AAA, 24'h555555);
    push_req(KIND_SPARE, 15'h7FFF, 24'h000001);
    push_req(KIND_START, 15'd12345, 24'hFFFFFF);
    gen_raw = 15'd12345;
    gen_stamp = 0;
  endfunction

  // Runs of angle samples closed by a velocity sample, with some starts and noise
  function automatic void queue_random(input int count);
    int made, run_len, stride_max, roll;
    bit fwd, spin;
    logic [KIND_BITS-1:0] kind;
    logic [RAW_BITS-1:0] raw;
    logic [STAMP_BITS-1:0] stamp;
    made = 0;
    while (made < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        kind = KIND_BITS'($urandom_range(0, 3));
        raw = RAW_BITS'($urandom);
        stamp = STAMP_BITS'($urandom);
        push_req(kind, raw, stamp);
        gen_raw = raw;
        if (kind == KIND_VEL) gen_stamp = 32'(stamp);
        if (kind == KIND_START) gen_stamp = 0;
        made++;
      end else if (roll < 10) begin
        raw = RAW_BITS'($urandom);
        push_req(KIND_START, raw, STAMP_BITS'($urandom));
        gen_raw = raw;
        gen_stamp = 0;
        made++;
      end else begin
        fwd = $urandom_range(0, 1);
        // a fast spin piles up turns before a very short interval
        spin = ($urandom_range(0, 99) < 20);
        if (spin) begin
          run_len = $urandom_range(16, 40);
          stride_max = 2000;
        end else begin
          run_len = $urandom_range(0, 4);
          case ($urandom_range(0, 2))
            0: stride_max = 100;
            1: stride_max = 6000;
            default: stride_max = 32767;
          endcase
        end
        repeat (run_len) begin
          kind = ($urandom_range(0, 19) == 0) ? KIND_SPARE : KIND_ANGLE;
          push_req(kind, next_raw(stride_max, fwd), STAMP_BITS'($urandom));
        end
        raw = next_raw(stride_max, fwd);
        push_req(KIND_VEL, raw, next_stamp(spin));
        made += run_len + 1;
      end
    end
  endfunction

  task automatic set_config(input logic [TPU_BITS-1:0] tpu, input logic [THR_BITS-1:0] thr);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TPU;
    cfg_data <= CFG_BITS'(tpu);
    @(posedge clk);
    cfg_index <= CFG_THR;
    cfg_data <= thr;
    @(posedge clk);
    cfg_we <= 1'b0;
    tpu_cfg = tpu;
    thr_cfg = thr;
    settings_run++;
  endtask

  // Hold until every request is sent and answered, then let the block settle
  task automatic drain_results();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Request driver: offer queued requests with random gaps
  always @(posedge clk) begin : request_driver
    logic offer_now;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(predict_tracker(tx_req));
        sent_reqs++;
      end
      if (!s_tvalid || s_tready) begin
        offer_now = 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_reqs.size() != 0) begin
          tx_req = pending_reqs.pop_front();
          offer_now = 1'b1;
          gap_left <= pick_gap();
          s_tdata <= {1'b0, tx_req.stamp, tx_req.raw};
          s_tuser <= tx_req.kind;
        end
        s_tvalid <= offer_now;
      end
    end
  end

  // Result monitor: compare against the oldest expectation and throttle ready
  always @(posedge clk) begin : result_monitor
    tracker_result_t want;
    logic signed [ANGLE_BITS-1:0] got_angle;
    logic signed [VEL_BITS-1:0] got_vel;
    int hold;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_angle = m_tdata[ANGLE_BITS-1:0];
        got_vel = m_tdata[ANGLE_BITS +: VEL_BITS];
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: angle_counts %0d", got_angle);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          checked_results++;
          if (want.vel_ok) vel_results++;
          if (want.fallback) fallback_results++;
          if (got_angle !== want.angle) begin
            $error("angle_counts: expected %0d, got %0d", want.angle, got_angle);
            fail_count++;
          end
          if (got_vel !== want.vel) begin
            $error("velocity_cps: expected %0d, got %0d", want.vel, got_vel);
            fail_count++;
          end
          if (m_tuser[0] !== want.vel_ok) begin
            $error("velocity_valid: expected %0b, got %0b", want.vel_ok, m_tuser[0]);
            fail_count++;
          end
          if (m_tuser[1] !== want.fallback) begin
            $error("interval_fallback: expected %0b, got %0b", want.fallback, m_tuser[1]);
            fail_count++;
          end
        end
      end
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        m_tready <= 1'b0;
        stall_left <= HOLDOFF_CYCLES;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        hold = pick_gap();
        m_tready <= (hold == 0);
        stall_left <= (hold > 0) ? hold - 1 : 0;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("run stalled after %0d results", checked_results);
    $display("tb_top failed");
    $finish;
  end

  initial begin : stimulus
    logic [TPU_BITS-1:0] tpu_plan [8];
    logic [THR_BITS-1:0] thr_plan [8];
    tpu_plan = '{8'd1, 8'd255, 8'd0, 8'd255, 8'd37, 8'd9, 8'd0, 8'd0};
    thr_plan = '{15'd1, 15'd32767, 15'd0, 15'd0, 15'd16384, 15'd26214, 15'd0, 15'd0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    queue_directed();
    drain_results();

    foreach (tpu_plan[i]) begin
      if (i >= 6) begin
        tpu_plan[i] = TPU_BITS'($urandom_range(1, 255));
        thr_plan[i] = THR_BITS'($urandom_range(0, 32767));
      end
      set_config(tpu_plan[i], thr_plan[i]);
      @(negedge clk);
      // one phase runs flat out on both sides
      idling_on = (i != 2);
      queue_random(ITEMS_PER_PHASE);
      // stall the receiver while requests keep coming
      if (i == 4) holdoff_req = 1'b1;
      drain_results();
    end

    $display("Checked %0d results for %0d requests over %0d register settings",
             checked_results, sent_reqs, settings_run);
    $display("  %0d velocity results, %0d on the 1 ms fallback interval",
             vel_results, fallback_results);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
